// File: src/dht_pkg.sv
// Package for the descriptor handle table: transfer payload types, status and kind codes,
// and the command and status groups between the controller and the datapath.
// No dependencies.
package dht_pkg;

    // Request modes.
    localparam logic [1:0] MODE_PUT    = 2'd0;
    localparam logic [1:0] MODE_GET    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Entry kinds reported by a get.
    localparam logic [1:0] KIND_FREE   = 2'd0;
    localparam logic [1:0] KIND_STORED = 2'd1;
    localparam logic [1:0] KIND_SYS    = 2'd2;

    localparam int unsigned HANDLE_W = 17;
    localparam int unsigned DESC_W   = 16;
    localparam int unsigned BASE_W   = 16;

    // One slot word: used mark, descriptor, file flag.
    localparam int unsigned SLOT_W = DESC_W + 2;

    localparam logic [BASE_W-1:0] BASE_RESET = 16'd1024;

    typedef struct packed {
        logic [1:0]          mode;
        logic [HANDLE_W-1:0] handle;
        logic [DESC_W-1:0]   real_descriptor;
        logic                entry_is_file;
    } t_req;

    typedef struct packed {
        logic [1:0]          status;
        logic [HANDLE_W-1:0] new_handle;
        logic [1:0]          entry_kind;
        logic [DESC_W-1:0]   out_descriptor;
        logic                out_is_file;
    } t_rsp;

    // Which result the datapath forms.
    typedef enum logic [2:0] {
        RES_OK    = 3'd0,
        RES_FULL  = 3'd1,
        RES_RANGE = 3'd2,
        RES_SYS   = 3'd3,
        RES_PUT   = 3'd4,
        RES_GET   = 3'd5
    } t_res_sel;

    typedef struct packed {
        logic     latch_req;
        logic     scan_load;
        logic     scan_inc;
        logic     rd_scan;
        logic     wr_en;
        logic     wr_put;
        logic     wr_idx;
        logic     hint_after_put;
        logic     hint_lower;
        logic     res_load;
        t_res_sel res_sel;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       below_base;
        logic       out_of_range;
        logic       hint_full;
        logic       slot_used;
        logic       scan_last;
        logic       out_free;
    } t_dp_sts;

endpackage

// File: src/dht_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module dht_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/dht_datapath.sv
// Datapath of the descriptor handle table: request, result and output registers, base and hint
// registers, scan counter, handle decode and the slot RAM. Depends on dht_pkg and dht_ram.
module dht_datapath
    import dht_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_req              i_in_data,
    input  logic              i_cfg_we,
    input  logic [BASE_W-1:0] i_cfg_wdata,
    input  logic              i_out_ready,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    output logic              o_out_valid,
    output t_rsp              o_out_data
);

    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam int unsigned HW = $clog2(TABLE_DEPTH + 1);

    t_req              r_req;
    t_rsp              r_res;
    t_rsp              r_out;
    t_rsp              n_res;
    logic              r_out_valid;
    logic [BASE_W-1:0] r_base;
    logic [HW-1:0]     r_hint;
    logic [IW-1:0]     r_scan;

    logic                below;
    logic [HANDLE_W-1:0] diff;
    logic [IW-1:0]       idx;
    logic [IW-1:0]       raddr;
    logic [IW-1:0]       waddr;
    logic [SLOT_W-1:0]   wdata;
    logic [SLOT_W-1:0]   rdata;

    assign below = r_req.handle < HANDLE_W'(r_base);
    assign diff  = r_req.handle - HANDLE_W'(r_base);
    assign idx   = diff[IW-1:0];

    assign raddr = i_cmd.rd_scan ? r_scan : idx;
    assign waddr = i_cmd.wr_idx ? idx : r_scan;
    assign wdata = i_cmd.wr_put ? {1'b1, r_req.real_descriptor, r_req.entry_is_file}
                                : '0;

    dht_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        o_sts.mode         = r_req.mode;
        o_sts.below_base   = below;
        // A handle below the base wraps the difference, so the below term keeps it from counting as past the table.
        o_sts.out_of_range = !below && (diff >= HANDLE_W'(TABLE_DEPTH));
        o_sts.hint_full    = r_hint == HW'(TABLE_DEPTH);
        o_sts.slot_used    = rdata[SLOT_W-1];
        o_sts.scan_last    = r_scan == IW'(TABLE_DEPTH - 1);
        o_sts.out_free     = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_res = '0;
        case (i_cmd.res_sel)
            RES_FULL: begin
                n_res.status = ST_FULL;
            end
            RES_RANGE: begin
                n_res.status = ST_RANGE;
            end
            RES_SYS: begin
                n_res.entry_kind     = KIND_SYS;
                n_res.out_descriptor = r_req.handle[DESC_W-1:0];
            end
            RES_PUT: begin
                n_res.new_handle = HANDLE_W'(r_scan) + HANDLE_W'(r_base);
            end
            RES_GET: begin
                if (rdata[SLOT_W-1]) begin
                    n_res.entry_kind     = KIND_STORED;
                    n_res.out_descriptor = rdata[DESC_W:1];
                    n_res.out_is_file    = rdata[0];
                end else begin
                    n_res.entry_kind = KIND_FREE;
                end
            end
            default: begin
                n_res.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= BASE_RESET;
            r_hint      <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (i_cmd.hint_after_put) begin
                r_hint <= HW'(r_scan) + HW'(1);
            end else if (i_cmd.hint_lower && (HW'(idx) < r_hint)) begin
                r_hint <= HW'(idx);
            end
            if (i_cmd.scan_load) begin
                r_scan <= r_hint[IW-1:0];
            end else if (i_cmd.scan_inc) begin
                r_scan <= r_scan + IW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_req <= i_in_data;
        end
        if (i_cmd.res_load) begin
            r_res <= n_res;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: src/dht_ctrl.sv
// Controller of the descriptor handle table: sequences the clearing pass, request decode,
// the put scan, the get slot check and the result hand-off. Depends on dht_pkg.
module dht_ctrl
    import dht_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_GET_CHK,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.scan_inc = !i_sts.scan_last;
                if (i_sts.scan_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.latch_req = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state        = S_RESP;
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = RES_OK;
                unique case (i_sts.mode)
                    MODE_PUT: begin
                        if (i_sts.hint_full) begin
                            o_cmd.res_sel = RES_FULL;
                        end else begin
                            o_cmd.res_load  = 1'b0;
                            o_cmd.scan_load = 1'b1;
                            n_state         = S_SCAN_RD;
                        end
                    end
                    MODE_GET: begin
                        if (i_sts.below_base) begin
                            o_cmd.res_sel = RES_SYS;
                        end else if (i_sts.out_of_range) begin
                            o_cmd.res_sel = RES_RANGE;
                        end else begin
                            // The slot read is issued now at the decoded index.
                            o_cmd.res_load = 1'b0;
                            n_state        = S_GET_CHK;
                        end
                    end
                    MODE_REMOVE: begin
                        if (i_sts.out_of_range) begin
                            o_cmd.res_sel = RES_RANGE;
                        end else if (!i_sts.below_base) begin
                            o_cmd.wr_en      = 1'b1;
                            o_cmd.wr_idx     = 1'b1;
                            o_cmd.hint_lower = 1'b1;
                        end
                    end
                    default: begin
                        o_cmd.res_sel = RES_OK;
                    end
                endcase
            end
            S_SCAN_RD: begin
                o_cmd.rd_scan = 1'b1;
                n_state       = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                o_cmd.rd_scan = 1'b1;
                if (!i_sts.slot_used) begin
                    o_cmd.wr_en          = 1'b1;
                    o_cmd.wr_put         = 1'b1;
                    o_cmd.hint_after_put = 1'b1;
                    o_cmd.res_load       = 1'b1;
                    o_cmd.res_sel        = RES_PUT;
                    n_state              = S_RESP;
                end else if (i_sts.scan_last) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_FULL;
                    n_state        = S_RESP;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            S_GET_CHK: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = RES_GET;
                n_state        = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/descriptor_handle_table.sv
// Top level of the descriptor handle table: controller, datapath and checks.
// Depends on dht_pkg, dht_ctrl and dht_datapath.

// The block hands out handles for a table of TABLE_DEPTH descriptor slots held in one
// RAM with a registered read port. After reset a clearing pass writes every slot free,
// one slot a cycle, and no request transfer is taken until the pass is done; writes to
// handle_base are taken at any time. Requests are served one at a time. A put loads the
// scan from the first-free hint and reads the slots one after another, a read state and
// a check state per slot examined, up to the last slot; a put on a full hint answers
// full without a scan. A get inside the table reads its slot before its result is
// formed; every other request forms its result straight from the decode. The result
// sits in an output register, so the next request transfer is taken while it waits to
// be taken; that next result is then held back until the waiting one has been
// transferred.
// A full table answers status full; slots freed below the hint are only reused once a
// remove has lowered the hint to them.
module descriptor_handle_table
    import dht_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_req              i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_rsp              o_out_data,
    input  logic              i_cfg_we,
    input  logic [BASE_W-1:0] i_cfg_wdata
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    dht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    dht_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // A result is never loaded over one that has not been transferred.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("result loaded while the output register is still occupied");

    // A put only ever claims a slot that was read as free.
    a_put_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.wr_en && w_cmd.wr_put) |-> !w_sts.slot_used)
        else $error("put wrote a slot that is in use");

    // One request at a time: an input transfer is followed by a busy cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a request is in progress");

    // The scan counter never steps past the last slot.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_inc |-> !w_sts.scan_last)
        else $error("scan stepped past the end of the table");

endmodule
